// ===== sv/sks_pkg.sv =====
package sks_pkg;

  // Width of the noise and uncertainty values (unsigned Q8.8).
  localparam int unsigned UNC_W = 16;
  // Width of the gain denominator p + r.
  localparam int unsigned DEN_W = UNC_W + 1;

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_MEAS_NOISE    = 2'd0;
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
  localparam logic [1:0] REG_INIT_UNC      = 2'd2;

  // Register reset values: 7.5 and 1.0 in Q8.8.
  localparam logic [UNC_W-1:0] MEAS_NOISE_RST    = 16'd1920;
  localparam logic [UNC_W-1:0] PROCESS_NOISE_RST = 16'd256;
  localparam logic [UNC_W-1:0] INIT_UNC_RST      = 16'd256;

  // Commands from the controller to the datapath, at most one per cycle.
  typedef struct packed {
    logic load;       // take the input item, seed on a first sample
    logic pred;       // predicted uncertainty and divisor
    logic div_first;  // integer quotient bit of the gain
    logic div_step;   // one fractional quotient bit
    logic mul;        // both products
    logic upd;        // round, saturate, commit the new state
    logic out_load;   // copy the state to the output register
  } sks_cmd_t;

endpackage

// ===== sv/scalar_kalman_snr_smoother.sv =====
// Scalar Kalman smoother for link SNR samples in signed Q8.8 dB. Each item
// gives one result: the filtered estimate, its uncertainty and the last flag.
// A first flag seeds the estimate with the sample and the uncertainty with
// the initial_uncertainty register. After an item is accepted, the controller
// steps through predict, the integer gain bit, the fractional gain bits,
// multiply, update and output load; no new item is taken until the result is
// loaded. The gain p/(p+r) comes from a restoring divider that produces one
// quotient bit per cycle. The block takes a new item while a finished result
// still waits in the output register. Registers (32-bit APB, byte addresses):
// 0x0 meas_noise, 0x4 process_noise, 0x8 initial_uncertainty, all unsigned Q8.8; write them only while idle.
module scalar_kalman_snr_smoother #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]   snr_sample_i,
  input  logic                      first_sample_i,
  input  logic                      last_sample_i,
  // Output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]   snr_estimate_o,
  output logic [sks_pkg::UNC_W-1:0] uncertainty_o,
  output logic                      final_result_o
);
  import sks_pkg::*;

  logic [UNC_W-1:0] meas_noise_q;
  logic [UNC_W-1:0] process_noise_q;
  logic [UNC_W-1:0] init_unc_q;
  logic             cfg_wr;
  sks_cmd_t         cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register writes; other addresses are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_noise_q    <= MEAS_NOISE_RST;
      process_noise_q <= PROCESS_NOISE_RST;
      init_unc_q      <= INIT_UNC_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MEAS_NOISE:    meas_noise_q    <= pwdata[UNC_W-1:0];
        REG_PROCESS_NOISE: process_noise_q <= pwdata[UNC_W-1:0];
        REG_INIT_UNC:      init_unc_q      <= pwdata[UNC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_MEAS_NOISE:    prdata = {16'd0, meas_noise_q};
      REG_PROCESS_NOISE: prdata = {16'd0, process_noise_q};
      REG_INIT_UNC:      prdata = {16'd0, init_unc_q};
      default:           prdata = '0;
    endcase
  end

  sks_ctrl #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sks_dpath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .snr_sample_i    (snr_sample_i),
    .first_sample_i  (first_sample_i),
    .last_sample_i   (last_sample_i),
    .meas_noise_i    (meas_noise_q),
    .process_noise_i (process_noise_q),
    .init_unc_i      (init_unc_q),
    .snr_estimate_o  (snr_estimate_o),
    .uncertainty_o   (uncertainty_o),
    .final_result_o  (final_result_o)
  );

  // The controller issues at most one datapath command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("more than one datapath command at once");

  // An accepted item keeps the input side stalled while it is worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  // A new result is only loaded at the end of an item's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> ($past(cmd.upd) || $past(cmd.out_load) == 1'b0) && in_stall_o)
    else $error("result loaded outside the end of an item");

endmodule

// ===== sv/sks_ctrl.sv =====
module sks_ctrl #(
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sks_pkg::sks_cmd_t cmd_o
);
  import sks_pkg::*;

  localparam int unsigned CNT_W = $clog2(GAIN_FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIV0,
    S_DIV,
    S_MUL,
    S_UPD,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PRED;
        end
      end
      S_PRED: begin
        cmd_o.pred = 1'b1;
        state_d    = S_DIV0;
      end
      S_DIV0: begin
        cmd_o.div_first = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(GAIN_FRAC_BITS - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, step counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/sks_dpath.sv =====
module sks_dpath #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sks_pkg::sks_cmd_t         cmd_i,
  input  logic [SAMPLE_WIDTH-1:0]   snr_sample_i,
  input  logic                      first_sample_i,
  input  logic                      last_sample_i,
  input  logic [sks_pkg::UNC_W-1:0] meas_noise_i,
  input  logic [sks_pkg::UNC_W-1:0] process_noise_i,
  input  logic [sks_pkg::UNC_W-1:0] init_unc_i,
  output logic [SAMPLE_WIDTH-1:0]   snr_estimate_o,
  output logic [sks_pkg::UNC_W-1:0] uncertainty_o,
  output logic                      final_result_o
);
  import sks_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned GF    = GAIN_FRAC_BITS;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned PE_W  = SW + GF + 2;    // diff * gain
  localparam int unsigned PP_W  = GF + 1 + UNC_W; // (1 - gain) * p
  localparam int unsigned ST_W  = SW + 2;         // step and sum
  localparam logic [PE_W-1:0] HALF_E = PE_W'(1) << (GF - 1);
  localparam logic [PP_W-1:0] HALF_P = PP_W'(1) << (GF - 1);
  localparam logic [GF:0]     GAIN_ONE = (GF + 1)'(1) << GF;

  logic [SW-1:0]       smp_q;
  logic                last_q;
  logic [SW-1:0]       est_q;
  logic [UNC_W-1:0]    unc_q;
  logic [UNC_W-1:0]    p_q;
  logic [DEN_W-1:0]    den_q;
  logic [DEN_W-1:0]    rem_q;
  logic [GF-1:0]       quo_q;
  logic                top_q;
  logic                dzero_q;
  logic signed [PE_W-1:0] prod_e_q;
  logic [PP_W-1:0]     prod_p_q;
  logic [SW-1:0]       out_est_q;
  logic [UNC_W-1:0]    out_unc_q;
  logic                out_last_q;

  logic [DEN_W-1:0]    p_sum;
  logic [UNC_W-1:0]    p_sat;
  logic [DEN_W-1:0]    p_ext;
  logic [REM_W-1:0]    rem_sh;
  logic                step_ge;
  logic [GF-1:0]       gain;
  logic [GF:0]         one_minus;
  logic [SW:0]         diff;
  logic signed [PE_W-1:0] rnd_e;
  logic signed [ST_W-1:0] step;
  logic signed [ST_W-1:0] nxt;
  logic [SW-1:0]       nxt_sat;
  logic [PP_W-1:0]     rnd_p;

  // Predicted uncertainty, saturated to 16 bits.
  assign p_sum = {1'b0, unc_q} + {1'b0, process_noise_i};
  assign p_sat = p_sum[DEN_W-1] ? {UNC_W{1'b1}} : p_sum[UNC_W-1:0];
  assign p_ext = {1'b0, p_q};

  // Restoring division step: one fractional gain bit per cycle.
  assign rem_sh  = {rem_q, 1'b0};
  assign step_ge = (rem_sh >= {1'b0, den_q});

  // Gain is zero for a zero divisor and clamps just below one.
  always_comb begin
    if (dzero_q) begin
      gain = '0;
    end else if (top_q) begin
      gain = '1;
    end else begin
      gain = quo_q;
    end
  end

  assign one_minus = GAIN_ONE - {1'b0, gain};
  assign diff      = {smp_q[SW-1], smp_q} - {est_q[SW-1], est_q};

  // Rounded step (ties toward plus infinity) and saturated new estimate.
  assign rnd_e = prod_e_q + $signed(HALF_E);
  assign step  = rnd_e[PE_W-1:GF];
  assign nxt   = ST_W'($signed(est_q)) + step;
  always_comb begin
    if (nxt[ST_W-1:SW-1] == '0 || nxt[ST_W-1:SW-1] == '1) begin
      nxt_sat = nxt[SW-1:0];
    end else if (nxt[ST_W-1]) begin
      nxt_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      nxt_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign rnd_p = prod_p_q + HALF_P;

  // Filter state: estimate and uncertainty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      unc_q <= '0;
    end else begin
      if (cmd_i.load && first_sample_i) begin
        est_q <= snr_sample_i;
        unc_q <= init_unc_i;
      end else if (cmd_i.upd) begin
        est_q <= nxt_sat;
        unc_q <= rnd_p[GF+UNC_W-1:GF];
      end
    end
  end

  // Working registers for one item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q  <= snr_sample_i;
      last_q <= last_sample_i;
    end
    if (cmd_i.pred) begin
      p_q   <= p_sat;
      den_q <= {1'b0, p_sat} + {1'b0, meas_noise_i};
    end
    if (cmd_i.div_first) begin
      top_q   <= (p_ext >= den_q);
      rem_q   <= (p_ext >= den_q) ? (p_ext - den_q) : p_ext;
      quo_q   <= '0;
      dzero_q <= (den_q == '0);
    end
    if (cmd_i.div_step) begin
      rem_q <= step_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[GF-2:0], step_ge};
    end
    if (cmd_i.mul) begin
      prod_e_q <= PE_W'($signed(diff)) * PE_W'($signed({1'b0, gain}));
      prod_p_q <= PP_W'(one_minus) * PP_W'(p_q);
    end
    if (cmd_i.out_load) begin
      out_est_q  <= est_q;
      out_unc_q  <= unc_q;
      out_last_q <= last_q;
    end
  end

  assign snr_estimate_o = out_est_q;
  assign uncertainty_o  = out_unc_q;
  assign final_result_o = out_last_q;

endmodule
